// ===== hw/rtl/ncc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared constants, register codes and pipeline tag type for the
// nearest-centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

  // parameter defaults
  localparam int MaxDimsDef     = 8;
  localparam int MaxClustersDef = 16;
  localparam int CoordBitsDef   = 16;

  // fixed field widths
  localparam int IdxOutW   = 4;
  localparam int DistW     = 35;
  localparam int DimsW     = 4;
  localparam int ClustersW = 5;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 5;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDims     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegClusters = 1'b1;

  // item modes
  localparam logic ModeLoad     = 1'b0;
  localparam logic ModeClassify = 1'b1;

  // control that travels alongside one centroid row
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ncc_tag_t;

endpackage

// ===== hw/rtl/ncc_lane.sv =====
// ----------------------------------------------------------------------------
// ncc_lane
// One dimension lane: difference of point and centroid coordinate, then its
// square, each step registered.
// ----------------------------------------------------------------------------
module ncc_lane #(
  parameter int COORD_BITS = ncc_pkg::CoordBitsDef
) (
  input  logic                      clk_i,
  input  logic [COORD_BITS-1:0]     pt_i,
  input  logic [COORD_BITS-1:0]     ctr_i,
  input  logic                      en_i,
  output logic [2*COORD_BITS-1:0]   sq_o
);

  localparam int SqW = 2 * COORD_BITS;

  logic signed [COORD_BITS:0] diff_d, diff_q;
  logic        [COORD_BITS:0] mag;
  logic    [2*COORD_BITS+1:0] prod;
  logic             [SqW-1:0] sq_d, sq_q;

  always_comb begin
    diff_d = signed'({pt_i[COORD_BITS-1], pt_i}) - signed'({ctr_i[COORD_BITS-1], ctr_i});
  end

  always_comb begin
    mag  = diff_q[COORD_BITS] ? unsigned'(-diff_q) : unsigned'(diff_q);
    prod = mag * mag;
    // magnitude stays below 2**COORD_BITS, so the square fits SqW bits
    sq_d = en_i ? prod[SqW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

// ===== hw/rtl/ncc_merge.sv =====
// ----------------------------------------------------------------------------
// ncc_merge
// Sums the lane squares of one centroid and keeps the running minimum and
// its index; lower index is kept on a tie.
// ----------------------------------------------------------------------------
module ncc_merge #(
  parameter int MAX_DIMS = ncc_pkg::MaxDimsDef,
  parameter int SQ_W     = 2 * ncc_pkg::CoordBitsDef,
  parameter int SUM_W    = 2 * ncc_pkg::CoordBitsDef + 3,
  parameter int IDX_W    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ncc_pkg::ncc_tag_t    tag_i,
  input  logic [SQ_W-1:0]      sq_i [MAX_DIMS],
  output logic [SUM_W-1:0]     best_dist_o,
  output logic [IDX_W-1:0]     best_idx_o,
  output logic                 done_o
);

  ncc_pkg::ncc_tag_t tag_q;
  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [SUM_W-1:0]  best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [IDX_W-1:0]  cnt_q, cur_idx;
  logic              done_q;

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum_d = sum_d + SUM_W'(sq_i[d]);
    end
  end

  assign cur_idx = tag_q.first ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.valid && tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (tag_q.valid) begin
      cnt_q <= cur_idx;
      // strict compare keeps the earliest centroid on equal distance
      if (tag_q.first || (sum_q < best_q)) begin
        best_q     <= sum_q;
        best_idx_q <= cur_idx;
      end
    end
  end

  assign best_dist_o = best_q;
  assign best_idx_o  = best_idx_q;
  assign done_o      = done_q;

endmodule

// ===== hw/rtl/nearest_centroid_classifier.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// Centroid table with a nearest-centroid search by squared Euclidean distance.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one centroid row and gives no result. A classify
// item (mode 1) reads one centroid row per cycle from the centroid memory, all
// dimensions in parallel lanes, through the memory read, lane and merge
// registers into the output register; the memory read port sets that pace.
// A new item is taken while the previous result still waits at the output.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier #(
  parameter int MAX_DIMS     = ncc_pkg::MaxDimsDef,
  parameter int MAX_CLUSTERS = ncc_pkg::MaxClustersDef,
  parameter int COORD_BITS   = ncc_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ncc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ncc_pkg::CfgDataW-1:0]   cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [3:0]                     centroid_index_i,
  input  logic [COORD_BITS-1:0]          coord_0_i,
  input  logic [COORD_BITS-1:0]          coord_1_i,
  input  logic [COORD_BITS-1:0]          coord_2_i,
  input  logic [COORD_BITS-1:0]          coord_3_i,
  input  logic [COORD_BITS-1:0]          coord_4_i,
  input  logic [COORD_BITS-1:0]          coord_5_i,
  input  logic [COORD_BITS-1:0]          coord_6_i,
  input  logic [COORD_BITS-1:0]          coord_7_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ncc_pkg::IdxOutW-1:0]    winner_index_o,
  output logic [ncc_pkg::DistW-1:0]      min_distance_sq_o
);

  localparam int CidxW = $clog2(MAX_CLUSTERS);
  localparam int RowW  = MAX_DIMS * COORD_BITS;
  localparam int SqW   = 2 * COORD_BITS;
  localparam int SumW  = SqW + $clog2(MAX_DIMS);
  localparam int CmpW  = (SumW > ncc_pkg::DistW) ? SumW : ncc_pkg::DistW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [ncc_pkg::DimsW-1:0]     dims_q;
  logic [ncc_pkg::ClustersW-1:0] clusters_q;

  logic [COORD_BITS-1:0] coords [8];
  logic [RowW-1:0]       in_row;
  logic [RowW-1:0]       pt_q;
  logic [RowW-1:0]       rd_data_q;
  logic [RowW-1:0]       centroid_mem_q [MAX_CLUSTERS];

  logic [MAX_DIMS-1:0]   dim_en_d, dim_en_q;
  logic [ncc_pkg::DimsW-1:0] nd;
  logic [CidxW-1:0]      last_d, last_q;
  logic [CidxW-1:0]      cnt_q;
  logic [CidxW-1:0]      wr_addr;

  logic in_acc, load_acc, class_acc, load_wr;
  logic res_done, out_free, out_load;

  ncc_pkg::ncc_tag_t tag0, tag1_q, tag2_q, tag3_q;

  logic [SqW-1:0]   sq [MAX_DIMS];
  logic [SumW-1:0]  best_dist;
  logic [CidxW-1:0] best_idx;
  logic [CmpW-1:0]  best_ext;

  logic                          out_valid_q;
  logic [ncc_pkg::IdxOutW-1:0]   winner_q;
  logic [ncc_pkg::DistW-1:0]     dist_q, dist_d;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q     <= ncc_pkg::DimsW'(8);
      clusters_q <= ncc_pkg::ClustersW'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ncc_pkg::RegDims:     dims_q     <= cfg_data_i[ncc_pkg::DimsW-1:0];
        ncc_pkg::RegClusters: clusters_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- input side ----------------
  assign coords = '{coord_0_i, coord_1_i, coord_2_i, coord_3_i,
                    coord_4_i, coord_5_i, coord_6_i, coord_7_i};

  always_comb begin
    in_row = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_row[d*COORD_BITS +: COORD_BITS] = coords[d];
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (mode_i == ncc_pkg::ModeLoad);
  assign class_acc  = in_acc && (mode_i == ncc_pkg::ModeClassify);
  assign load_wr    = load_acc && (32'(centroid_index_i) < MAX_CLUSTERS);
  assign wr_addr    = CidxW'(centroid_index_i);

  // clamp counts to the valid ranges
  always_comb begin
    if (dims_q == '0) begin
      nd = ncc_pkg::DimsW'(1);
    end else if (32'(dims_q) > MAX_DIMS) begin
      nd = ncc_pkg::DimsW'(MAX_DIMS);
    end else begin
      nd = dims_q;
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_en_d[d] = ncc_pkg::DimsW'(d) < nd;
    end
    if (clusters_q == '0) begin
      last_d = '0;
    end else if (32'(clusters_q) >= MAX_CLUSTERS) begin
      last_d = CidxW'(MAX_CLUSTERS - 1);
    end else begin
      last_d = CidxW'(clusters_q - 1'b1);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (class_acc) state_d = StIssue;
      end
      StIssue: begin
        if (cnt_q == last_q) state_d = StWait;
      end
      StWait: begin
        if (res_done) state_d = out_free ? StIdle : StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (class_acc) begin
        cnt_q <= '0;
      end else if (state_q == StIssue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (class_acc) begin
      pt_q     <= in_row;
      dim_en_q <= dim_en_d;
      last_q   <= last_d;
    end
  end

  // ---------------- centroid memory ----------------
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      centroid_mem_q[wr_addr] <= in_row;
    end
    if (state_q == StIssue) begin
      rd_data_q <= centroid_mem_q[cnt_q];
    end
  end

  // tags follow the row through read, difference and square stages
  always_comb begin
    tag0.valid = (state_q == StIssue);
    tag0.first = (cnt_q == '0);
    tag0.last  = (cnt_q == last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag0;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // ---------------- lanes and merge ----------------
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
    ncc_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .pt_i  (pt_q[g*COORD_BITS +: COORD_BITS]),
      .ctr_i (rd_data_q[g*COORD_BITS +: COORD_BITS]),
      .en_i  (dim_en_q[g]),
      .sq_o  (sq[g])
    );
  end

  ncc_merge #(
    .MAX_DIMS (MAX_DIMS),
    .SQ_W     (SqW),
    .SUM_W    (SumW),
    .IDX_W    (CidxW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag3_q),
    .sq_i        (sq),
    .best_dist_o (best_dist),
    .best_idx_o  (best_idx),
    .done_o      (res_done)
  );

  // ---------------- output register ----------------
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && (((state_q == StWait) && res_done) || (state_q == StDone));

  // saturate to the output width
  assign best_ext = CmpW'(best_dist);
  assign dist_d   = (best_ext > CmpW'({ncc_pkg::DistW{1'b1}})) ?
                    {ncc_pkg::DistW{1'b1}} : best_ext[ncc_pkg::DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      winner_q <= ncc_pkg::IdxOutW'(best_idx);
      dist_q   <= dist_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign winner_index_o    = winner_q;
  assign min_distance_sq_o = dist_q;

endmodule

// ===== hw/rtl/ncc_checker.sv =====
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks for the nearest-centroid classifier, bound to the top.
// ----------------------------------------------------------------------------
module ncc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         mode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ncc_pkg::IdxOutW-1:0]  winner_index_o,
  input logic [ncc_pkg::DistW-1:0]    min_distance_sq_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(winner_index_o)
      && $stable(min_distance_sq_o))
    else $error("result changed while stalled");

  // a classify transaction occupies the block
  a_class_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == ncc_pkg::ModeClassify) |=> !in_ready_o)
    else $error("input still ready after classify transaction");

  // a load transaction does not make the block busy
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == ncc_pkg::ModeLoad) |=> in_ready_o)
    else $error("block busy after load transaction");

  // a new result appears only as the search completes
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while search still running");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .mode_i            (mode_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .winner_index_o    (winner_index_o),
  .min_distance_sq_o (min_distance_sq_o)
);
